// ===== hdl/v4alu_pkg.sv =====
// Shared types, stage plan and helpers for the four-component vector unit.
package v4alu_pkg;

  // Number of vector lanes (x, y, z, w)
  localparam int LANES = 4;

  // Square root: one root bit per stage, 33 bits cover a sum of four squares
  localparam int SQ_BITS = 33;
  // Divider: one quotient bit per stage, enough to expose any overflow
  localparam int QW = 34;
  // Width of the doubled divisor
  localparam int DW = 34;

  // Pipeline stage plan (index of the stage whose registers load)
  localparam int STG_MUL  = 0;
  localparam int STG_RND  = 1;
  localparam int STG_SQ0  = 2;
  localparam int STG_MAG  = STG_SQ0 + SQ_BITS;
  localparam int STG_DP1  = STG_MAG + 1;
  localparam int STG_DP2  = STG_DP1 + 1;
  localparam int STG_DP3  = STG_DP2 + 1;
  localparam int STG_OVF  = STG_DP3 + 1;
  localparam int STG_DV0  = STG_OVF + 1;
  localparam int STG_FIN  = STG_DV0 + QW;
  localparam int N_STAGES = STG_FIN + 1;

  typedef enum logic [3:0] {
    KIND_ADD   = 4'd0,
    KIND_SUB   = 4'd1,
    KIND_NEG   = 4'd2,
    KIND_SCALE = 4'd3,
    KIND_DIV   = 4'd4,
    KIND_MAG   = 4'd5,
    KIND_NORM  = 4'd6,
    KIND_DOT   = 4'd7,
    KIND_CROSS = 4'd8,
    KIND_EQUAL = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DIVZ = 2'd1,
    STATUS_SAT  = 2'd2
  } status_e;

  typedef enum logic {
    CFG_ABS_TOL = 1'b0,
    CFG_REL_TOL = 1'b1
  } cfg_idx_e;

  // Saturated 32-bit value with its clamp flag
  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } scal_t;

  // Per-lane result handed to the output assembly
  typedef struct packed {
    logic [31:0] r;
    logic        sat;
    logic        eq;
    logic        dz;
  } lane_out_t;

  localparam logic signed [65:0] MAX66 = 66'sd2147483647;
  localparam logic signed [65:0] MIN66 = -66'sd2147483648;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic scal_t sat32(input logic signed [65:0] v);
    scal_t res;
    if (v > MAX66) begin
      res = '{value: 32'h7fff_ffff, sat: 1'b1};
    end else if (v < MIN66) begin
      res = '{value: 32'h8000_0000, sat: 1'b1};
    end else begin
      res = '{value: v[31:0], sat: 1'b0};
    end
    return res;
  endfunction

endpackage

// ===== hdl/v4alu_lane.sv =====
// One vector lane: products, element-wise ops, equality and a pipelined divider.
module v4alu_lane import v4alu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  kind_e              kind_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] f_i,
  input  logic signed [31:0] xa_i,
  input  logic signed [31:0] xb_i,
  input  logic signed [31:0] xc_i,
  input  logic signed [31:0] xd_i,
  input  logic [30:0]        abs_tol_i,
  input  logic [15:0]        rel_tol_i,
  input  logic [32:0]        mag_i,
  output logic signed [63:0] prod_o,
  output lane_out_t          res_o
);

  localparam int NW = FRAC_BITS + 35;
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;
  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] a;
    logic signed [31:0] f;
    scal_t              early;
    logic               eq;
  } carry_t;

  // Stage 0 registers
  kind_e              kind0_q;
  logic signed [31:0] a0_q, f0_q;
  logic signed [63:0] m0_q, m1_q;
  logic signed [32:0] simp0_q;
  logic [32:0]        ad0_q;
  logic [31:0]        mx0_q;

  // Later stages
  carry_t             car_q  [STG_RND:STG_FIN-1];
  logic [32:0]        dabs_q;
  logic               sgn_q;
  logic               dz_q   [STG_DP1:STG_FIN-1];
  logic signed [NW-1:0] nsum_q;
  logic [DW-1:0]      dv_q   [STG_DP2:STG_FIN-1];
  logic [NW-1:0]      mnum_q;
  logic               neg_q  [STG_DP3:STG_FIN-1];
  logic               ovf_q  [STG_OVF:STG_FIN-1];
  logic [CW-1:0]      rem_q  [STG_OVF:STG_FIN-1];
  logic [QW-1:0]      quo_q  [STG_OVF:STG_FIN-1];
  lane_out_t          res_q;

  // Stage 0: operand select and element-wise arithmetic
  logic signed [31:0] op0, op1;
  logic signed [32:0] aa, bb, diff, simp_d;
  logic [32:0]        ad_d, ma33, mb33;
  logic [31:0]        mx_d;

  always_comb begin
    aa = 33'(a_i);
    bb = 33'(b_i);
    case (kind_i)
      KIND_SCALE: begin
        op0 = a_i;
        op1 = f_i;
      end
      KIND_MAG, KIND_NORM: begin
        op0 = a_i;
        op1 = a_i;
      end
      KIND_CROSS: begin
        op0 = xa_i;
        op1 = xb_i;
      end
      default: begin
        op0 = a_i;
        op1 = b_i;
      end
    endcase
    case (kind_i)
      KIND_ADD: simp_d = aa + bb;
      KIND_SUB: simp_d = aa - bb;
      KIND_NEG: simp_d = -aa;
      default:  simp_d = '0;
    endcase
    diff = aa - bb;
    ad_d = diff[32] ? 33'(-diff) : 33'(diff);
    ma33 = aa[32] ? 33'(-aa) : 33'(aa);
    mb33 = bb[32] ? 33'(-bb) : 33'(bb);
    mx_d = (ma33 > mb33) ? ma33[31:0] : mb33[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind0_q <= kind_i;
      a0_q    <= a_i;
      f0_q    <= f_i;
      m0_q    <= op0 * op1;
      m1_q    <= xc_i * xd_i;
      simp0_q <= simp_d;
      ad0_q   <= ad_d;
      mx0_q   <= mx_d;
    end
  end

  assign prod_o = m0_q;

  // Stage 1: round products, saturate, compare within tolerance
  logic signed [65:0] x1, rnd1;
  logic [48:0]        rel_lhs, rel_rhs;
  carry_t             car1_d;

  always_comb begin
    x1 = (kind0_q == KIND_CROSS) ? (66'(m0_q) - 66'(m1_q)) : 66'(m0_q);
    rnd1 = (x1 + HALF) >>> FRAC_BITS;
    rel_lhs = {ad0_q, 16'd0};
    rel_rhs = 49'(mx0_q) * 49'(rel_tol_i);
    car1_d.kind = kind0_q;
    car1_d.a    = a0_q;
    car1_d.f    = f0_q;
    case (kind0_q)
      KIND_ADD, KIND_SUB, KIND_NEG: car1_d.early = sat32(66'(simp0_q));
      KIND_SCALE, KIND_CROSS:       car1_d.early = sat32(rnd1);
      default:                      car1_d.early = '{value: '0, sat: 1'b0};
    endcase
    car1_d.eq = (kind0_q == KIND_EQUAL) &&
                ((ad0_q <= 33'(abs_tol_i)) || (rel_lhs <= rel_rhs));
  end

  // Divisor select and sign fold
  carry_t             cm;
  logic signed [33:0] dd;
  logic [33:0]        dd_abs;
  logic               dz_d;

  always_comb begin
    cm = car_q[STG_MAG];
    dd = (cm.kind == KIND_DIV) ? 34'(cm.f) : $signed({1'b0, mag_i});
    dd_abs = dd[33] ? 34'(-dd) : 34'(dd);
    dz_d = ((cm.kind == KIND_DIV) && (cm.f == '0)) ||
           ((cm.kind == KIND_NORM) && (mag_i == '0));
  end

  // Doubled numerator plus divisor, signs folded
  logic signed [NW-1:0] n2, dext, nsum_d;
  logic [NW-1:0]        mnum_d;
  logic                 neg_d;

  always_comb begin
    n2 = NW'(car_q[STG_DP1].a) <<< (FRAC_BITS + 1);
    dext = $signed({{(NW - 33){1'b0}}, dabs_q});
    nsum_d = sgn_q ? (dext - n2) : (n2 + dext);
    neg_d = nsum_q[NW-1];
    mnum_d = neg_d ? (NW'(dv_q[STG_DP2]) + NW'(~nsum_q)) : NW'(nsum_q);
  end

  // Advance the pipeline registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      car_q[STG_RND] <= car1_d;
      for (int k = STG_RND + 1; k <= STG_FIN - 1; k++) begin
        car_q[k] <= car_q[k-1];
      end
      dabs_q <= dd_abs[32:0];
      sgn_q  <= dd[33];
      dz_q[STG_DP1] <= dz_d;
      for (int k = STG_DP1 + 1; k <= STG_FIN - 1; k++) begin
        dz_q[k] <= dz_q[k-1];
      end
      nsum_q <= nsum_d;
      dv_q[STG_DP2] <= {dabs_q, 1'b0};
      for (int k = STG_DP2 + 1; k <= STG_FIN - 1; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
      mnum_q <= mnum_d;
      neg_q[STG_DP3] <= neg_d;
      for (int k = STG_DP3 + 1; k <= STG_FIN - 1; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
      ovf_q[STG_OVF] <= CW'(mnum_q) >= (CW'(dv_q[STG_DP3]) << QW);
      rem_q[STG_OVF] <= CW'(mnum_q);
      quo_q[STG_OVF] <= '0;
      for (int k = STG_DV0; k <= STG_FIN - 1; k++) begin
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // Restoring divider, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int S = STG_DV0 + j;
    localparam int B = QW - 1 - j;
    logic [CW-1:0] trial;
    logic          take;

    assign trial = CW'(dv_q[S-1]) << B;
    assign take  = rem_q[S-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[S] <= take ? (rem_q[S-1] - trial) : rem_q[S-1];
        quo_q[S] <= quo_q[S-1] | (take ? (QW'(1) << B) : '0);
      end
    end
  end

  // Final: pick the lane result by kind
  carry_t             cf;
  logic signed [QW:0] qs;
  scal_t              dres;
  lane_out_t          res_d;

  always_comb begin
    cf = car_q[STG_FIN-1];
    qs = neg_q[STG_FIN-1] ? -$signed({1'b0, quo_q[STG_FIN-1]})
                          : $signed({1'b0, quo_q[STG_FIN-1]});
    if (ovf_q[STG_FIN-1]) begin
      dres = '{value: neg_q[STG_FIN-1] ? 32'h8000_0000 : 32'h7fff_ffff, sat: 1'b1};
    end else begin
      dres = sat32(66'(qs));
    end
    res_d.eq = cf.eq;
    case (cf.kind)
      KIND_DIV, KIND_NORM: begin
        res_d.dz  = dz_q[STG_FIN-1];
        res_d.r   = dz_q[STG_FIN-1] ? '0 : dres.value;
        res_d.sat = dz_q[STG_FIN-1] ? 1'b0 : dres.sat;
      end
      default: begin
        res_d.dz  = 1'b0;
        res_d.r   = cf.early.value;
        res_d.sat = cf.early.sat;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== hdl/v4alu_merge.sv =====
// Merge stage: dot product sum, sum of squares and pipelined square root.
module v4alu_merge import v4alu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  kind_e              kind_i,
  input  logic signed [63:0] prod_i [LANES],
  output logic [32:0]        mag_o,
  output scal_t              scal_o
);

  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  kind_e              kind_q [STG_MUL:STG_MAG-1];
  logic signed [65:0] dot1_q;
  scal_t              dsc_q  [STG_SQ0:STG_MAG-1];
  logic [32:0]        rt_q   [STG_RND:STG_MAG-1];
  logic [65:0]        rm_q   [STG_RND:STG_MAG-1];
  logic [32:0]        mag_q;
  scal_t              sc_q   [STG_MAG:STG_FIN];

  // Sum the dot terms and the squares
  logic signed [65:0] dot_d;
  logic [65:0]        sq_d;

  always_comb begin
    dot_d = 66'(prod_i[0]) + 66'(prod_i[1]) + 66'(prod_i[2]) + HALF;
    sq_d  = 66'(unsigned'(prod_i[0])) + 66'(unsigned'(prod_i[1])) +
            66'(unsigned'(prod_i[2])) + 66'(unsigned'(prod_i[3]));
  end

  // Round the magnitude and select the scalar result
  logic [32:0] mag_d;
  scal_t       sc_d;

  always_comb begin
    mag_d = (rm_q[STG_MAG-1] > 66'(rt_q[STG_MAG-1])) ? (rt_q[STG_MAG-1] + 33'd1)
                                                     : rt_q[STG_MAG-1];
    case (kind_q[STG_MAG-1])
      KIND_MAG: sc_d = sat32(66'(mag_d));
      KIND_DOT: sc_d = dsc_q[STG_MAG-1];
      default:  sc_d = '{value: '0, sat: 1'b0};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q[STG_MUL] <= kind_i;
      for (int k = STG_MUL + 1; k <= STG_MAG - 1; k++) begin
        kind_q[k] <= kind_q[k-1];
      end
      dot1_q <= dot_d;
      rm_q[STG_RND] <= sq_d;
      rt_q[STG_RND] <= '0;
      dsc_q[STG_SQ0] <= sat32(dot1_q >>> FRAC_BITS);
      for (int k = STG_SQ0 + 1; k <= STG_MAG - 1; k++) begin
        dsc_q[k] <= dsc_q[k-1];
      end
      mag_q <= mag_d;
      sc_q[STG_MAG] <= sc_d;
      for (int k = STG_MAG + 1; k <= STG_FIN; k++) begin
        sc_q[k] <= sc_q[k-1];
      end
    end
  end

  // Digit-by-digit square root, one root bit per stage
  for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
    localparam int S = STG_SQ0 + j;
    localparam int B = SQ_BITS - 1 - j;
    logic [65:0] trial;
    logic        take;

    assign trial = (66'(rt_q[S-1]) << (B + 1)) + (66'd1 << (2 * B));
    assign take  = rm_q[S-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rm_q[S] <= take ? (rm_q[S-1] - trial) : rm_q[S-1];
        rt_q[S] <= rt_q[S-1] | (take ? (33'd1 << B) : '0);
      end
    end
  end

  assign mag_o  = mag_q;
  assign scal_o = sc_q[STG_FIN];

endmodule

// ===== hdl/vector4_alu_core.sv =====
// Top level of the four-component fixed-point vector unit.
// Takes one operation per clock while ready; one result per operation, in order.
// Every transaction spends 75 pipeline stages inside the block, then enters a
// two-entry output queue, where a result offered on the output can be taken
// at the following edge at the earliest; the length is set by the 33-stage
// square root feeding the 34-stage divider in each lane. Throughput is one
// transaction per cycle while the consumer keeps up; when the queue holds two
// results the whole pipeline holds. Tolerance registers should be written
// only while no transaction is in flight.
module vector4_alu_core import v4alu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, factor (32 bits each)
  input  logic [287:0] s_axis_tdata,
  // kind
  input  logic [3:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // r_x, r_y, r_z, r_w, r_scalar (32 each), is_equal, status (2), zero pad
  output logic [167:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [30:0]  cfg_data_i
);

  typedef struct packed {
    logic [4:0]  pad;
    status_e     status;
    logic        is_equal;
    logic [31:0] r_scalar;
    logic [31:0] r_w;
    logic [31:0] r_z;
    logic [31:0] r_y;
    logic [31:0] r_x;
  } result_t;

  localparam logic [1:0] FIFO_FULL = 2'd2;

  logic [30:0]         abs_tol_q;
  logic [15:0]         rel_tol_q;
  logic [N_STAGES-1:0] v_q;
  result_t             fifo_q [2];
  logic                wr_q, rd_q;
  logic [1:0]          cnt_q;
  logic                en, push, pop;

  // Tolerance registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_tol_q <= 31'd1;
      rel_tol_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ABS_TOL: abs_tol_q <= cfg_data_i;
        CFG_REL_TOL: rel_tol_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Unpack the input transaction
  logic signed [31:0] vec_a [LANES];
  logic signed [31:0] vec_b [LANES];
  logic signed [31:0] factor;
  kind_e              kind;

  for (genvar i = 0; i < LANES; i++) begin : g_unpack
    assign vec_a[i] = s_axis_tdata[32*i +: 32];
    assign vec_b[i] = s_axis_tdata[32*(LANES+i) +: 32];
  end
  assign factor = s_axis_tdata[287:256];
  assign kind   = kind_e'(s_axis_tuser);

  // Lanes
  logic signed [63:0] prod [LANES];
  lane_out_t          lres [LANES];
  logic [32:0]        mag;
  scal_t              scal;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [31:0] xa, xb, xc, xd;
    if (i < 3) begin : g_cross
      assign xa = vec_a[(i+1)%3];
      assign xb = vec_b[(i+2)%3];
      assign xc = vec_a[(i+2)%3];
      assign xd = vec_b[(i+1)%3];
    end else begin : g_nocross
      assign xa = '0;
      assign xb = '0;
      assign xc = '0;
      assign xd = '0;
    end
    v4alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .kind_i    (kind),
      .a_i       (vec_a[i]),
      .b_i       (vec_b[i]),
      .f_i       (factor),
      .xa_i      (xa),
      .xb_i      (xb),
      .xc_i      (xc),
      .xd_i      (xd),
      .abs_tol_i (abs_tol_q),
      .rel_tol_i (rel_tol_q),
      .mag_i     (mag),
      .prod_o    (prod[i]),
      .res_o     (lres[i])
    );
  end

  v4alu_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .kind_i (kind),
    .prod_i (prod),
    .mag_o  (mag),
    .scal_o (scal)
  );

  // Assemble the result from the lanes and the merge stage
  result_t res_d;
  logic    any_sat;

  always_comb begin
    any_sat = scal.sat;
    res_d.is_equal = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      any_sat = any_sat | lres[i].sat;
      res_d.is_equal = res_d.is_equal & lres[i].eq;
    end
    res_d.pad = '0;
    if (lres[0].dz) begin
      res_d.status   = STATUS_DIVZ;
      res_d.r_x      = '0;
      res_d.r_y      = '0;
      res_d.r_z      = '0;
      res_d.r_w      = '0;
      res_d.r_scalar = '0;
      res_d.is_equal = 1'b0;
    end else begin
      res_d.status   = any_sat ? STATUS_SAT : STATUS_OK;
      res_d.r_x      = lres[0].r;
      res_d.r_y      = lres[1].r;
      res_d.r_z      = lres[2].r;
      res_d.r_w      = lres[3].r;
      res_d.r_scalar = scal.value;
    end
  end

  // Advance the pipeline while the output queue has room
  assign en   = (cnt_q != FIFO_FULL);
  assign push = en && v_q[STG_FIN];
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N_STAGES-2:0], s_axis_tvalid};
    end
  end

  // Output queue: hold up to two finished results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= res_d;
    end
  end

  result_t out_res;

  assign out_res       = fifo_q[rd_q];
  assign s_axis_tready = en;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = out_res;

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue count out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(v_q))
    else $error("pipeline moved while stalled");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[STG_FIN] && s_axis_tready) |=> m_axis_tvalid)
    else $error("finished result did not reach the output");

  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res.status == STATUS_DIVZ) |->
      (out_res.r_x == '0 && out_res.r_y == '0 && out_res.r_z == '0 &&
       out_res.r_w == '0 && out_res.r_scalar == '0 && !out_res.is_equal))
    else $error("divide-by-zero result carries data");
`endif

endmodule
